/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the semaphore table checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/cst_pkg.sv */
// ----------------------------------------------------------------------------
// cst_pkg
// sizes, command and status codes, and shared types of the semaphore table
// ----------------------------------------------------------------------------
package cst_pkg;

    // table geometry
    localparam int NUM_SEMAPHORES = 8;
    localparam int NUM_WAITERS    = 8;
    localparam int SLOT_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int WAIT_W = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
    localparam int USED_W = $clog2(NUM_SEMAPHORES + 1);

    // request and response field widths
    localparam int MODE_W   = 4;
    localparam int IDX_W    = 4;
    localparam int GEN_W    = 16;
    localparam int WIDX_W   = 3;
    localparam int PERMIT_W = 16;
    localparam int STATUS_W = 4;

    // command codes
    localparam logic [MODE_W-1:0] MODE_CREATE    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_TRY       = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BEGIN     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_POLL      = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CANCEL    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_AVAIL     = 4'd7;
    localparam logic [MODE_W-1:0] MODE_RESET_ALL = 4'd8;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK            = 4'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID       = 4'd1;
    localparam logic [STATUS_W-1:0] STAT_STALE         = 4'd2;
    localparam logic [STATUS_W-1:0] STAT_WOULD_BLOCK   = 4'd3;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED     = 4'd4;
    localparam logic [STATUS_W-1:0] STAT_DISCONNECTED  = 4'd5;
    localparam logic [STATUS_W-1:0] STAT_INVALID_STATE = 4'd6;
    localparam logic [STATUS_W-1:0] STAT_PENDING       = 4'd7;
    localparam logic [STATUS_W-1:0] STAT_CANCELLED     = 4'd8;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOT_SCAN,
        S_SWEEP,
        S_LOOKUP,
        S_WAIT_SCAN,
        S_RESP
    } state_t;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_GEN_ADV,
        ALU_INC_SAT,
        ALU_DEC
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [GEN_W-1:0]   a;
    } alu_req_t;

    // one semaphore slot
    typedef struct packed {
        logic                   alive;
        logic [GEN_W-1:0]       gen;
        logic [PERMIT_W-1:0]    permits;
        logic [NUM_WAITERS-1:0] active;
        logic [NUM_WAITERS-1:0] granted;
    } entry_t;

    // table write port
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        entry_t             data;
    } tbl_wr_t;

endpackage

/* rtl/cst_if.sv */
// ----------------------------------------------------------------------------
// cst_if
// request and response channels of the semaphore table
// ----------------------------------------------------------------------------
interface cst_cmd_if import cst_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [IDX_W-1:0]       sem_index;
    logic [GEN_W-1:0]       handle_generation;
    logic [WIDX_W-1:0]      waiter_index;
    logic [PERMIT_W-1:0]    start_permits;
    logic                   cancel_request;

    modport source (
        output valid, mode, sem_index, handle_generation, waiter_index,
               start_permits, cancel_request,
        input  ready
    );
    modport sink (
        input  valid, mode, sem_index, handle_generation, waiter_index,
               start_permits, cancel_request,
        output ready
    );
endinterface

interface cst_rsp_if import cst_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [IDX_W-1:0]       out_index;
    logic [GEN_W-1:0]       out_generation;
    logic [WIDX_W-1:0]      out_waiter;
    logic [PERMIT_W-1:0]    permits_available;

    modport source (
        output valid, status, out_index, out_generation, out_waiter,
               permits_available,
        input  ready
    );
    modport sink (
        input  valid, status, out_index, out_generation, out_waiter,
               permits_available,
        output ready
    );
endinterface

/* rtl/cst_alu.sv */
// ----------------------------------------------------------------------------
// cst_alu
// shared 16-bit unit: pass, generation advance, saturating increment, decrement
// ----------------------------------------------------------------------------
module cst_alu import cst_pkg::*; (
    input  alu_req_t            req,
    output logic [GEN_W-1:0]    y
);

    logic [GEN_W-1:0] sum;

    // one incrementer and one decrementer share the operand
    assign sum = req.a + GEN_W'(1);

    always_comb
    begin
        unique case (req.op)
            ALU_PASS:    y = req.a;
            ALU_GEN_ADV: y = (&req.a) ? GEN_W'(1) : sum;
            ALU_INC_SAT: y = (&req.a) ? req.a : sum;
            ALU_DEC:     y = req.a - GEN_W'(1);
            default:     y = req.a;
        endcase
    end

endmodule

/* rtl/cst_table.sv */
// ----------------------------------------------------------------------------
// cst_table
// semaphore slot storage, one read address and one write port
// ----------------------------------------------------------------------------
module cst_table import cst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SLOT_W-1:0]   rd_addr,
    output entry_t              rd_data,
    input  tbl_wr_t             wr
);

    entry_t mem_reg [NUM_SEMAPHORES];

    // slot entries, all cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SEMAPHORES; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // read at the sequencer's current slot
    assign rd_data = mem_reg[rd_addr];

endmodule

/* rtl/cst_ctrl.sv */
// ----------------------------------------------------------------------------
// cst_ctrl
// command sequencer: slot scan, reset sweep, lookup and waiter scan
// ----------------------------------------------------------------------------
module cst_ctrl import cst_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    cst_cmd_if.sink             cmd,
    cst_rsp_if.source           rsp,
    output logic [SLOT_W-1:0]   rd_addr,
    input  entry_t              rd_data,
    output tbl_wr_t             wr,
    output alu_req_t            alu_req,
    input  logic [GEN_W-1:0]    alu_y
);

    state_t                 state_reg, state_next;

    // latched request
    logic [MODE_W-1:0]      mode_reg;
    logic [IDX_W-1:0]       index_reg;
    logic [GEN_W-1:0]       gen_reg;
    logic [WIDX_W-1:0]      waiter_reg;
    logic [PERMIT_W-1:0]    init_reg;
    logic                   cancel_reg;

    // counters
    logic [SLOT_W-1:0]      scan_reg, scan_next;
    logic [WAIT_W-1:0]      wscan_reg, wscan_next;
    logic [USED_W-1:0]      used_reg, used_next;

    // response
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [IDX_W-1:0]       oidx_reg, oidx_next;
    logic [GEN_W-1:0]       ogen_reg, ogen_next;
    logic [WIDX_W-1:0]      owait_reg, owait_next;
    logic [PERMIT_W-1:0]    avail_reg, avail_next;

    logic                   accept;
    logic                   slot_ok;
    logic                   waiter_ok;
    logic                   handle_ok;
    logic [WAIT_W-1:0]      wsel;
    logic                   w_act, w_gr;
    logic                   s_act, s_gr;
    logic                   slot_last, wait_last, sweep_last;
    logic                   mode_bad;
    logic                   is_poll_cancel;

    assign accept = cmd.valid && cmd.ready;

    // conditions decoded from the request and the slot read
    always_comb
    begin
        slot_ok        = int'(index_reg) < NUM_SEMAPHORES;
        waiter_ok      = int'(waiter_reg) < NUM_WAITERS;
        handle_ok      = rd_data.alive && (rd_data.gen == gen_reg);
        wsel           = WAIT_W'(waiter_reg);
        w_act          = rd_data.active[wsel];
        w_gr           = rd_data.granted[wsel];
        s_act          = rd_data.active[wscan_reg];
        s_gr           = rd_data.granted[wscan_reg];
        slot_last      = scan_reg == SLOT_W'(NUM_SEMAPHORES - 1);
        wait_last      = wscan_reg == WAIT_W'(NUM_WAITERS - 1);
        sweep_last     = (USED_W'(scan_reg) + USED_W'(1)) == used_reg;
        mode_bad       = (mode_reg > MODE_RESET_ALL) || !slot_ok;
        is_poll_cancel = (mode_reg == MODE_POLL) || (mode_reg == MODE_CANCEL);
    end

    // table address: the request's slot or the scan position
    assign rd_addr = ((state_reg == S_LOOKUP) || (state_reg == S_WAIT_SCAN)) ?
                     SLOT_W'(index_reg) : scan_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.mode == MODE_CREATE)
                        state_next = S_SLOT_SCAN;
                    else if (cmd.mode == MODE_RESET_ALL)
                        state_next = (used_reg == '0) ? S_RESP : S_SWEEP;
                    else
                        state_next = S_LOOKUP;
                end
            end
            S_SLOT_SCAN:
            begin
                if (!rd_data.alive || slot_last)
                    state_next = S_RESP;
            end
            S_SWEEP:
            begin
                if (sweep_last)
                    state_next = S_RESP;
            end
            S_LOOKUP:
            begin
                if (((mode_reg == MODE_BEGIN) || (mode_reg == MODE_RELEASE)) &&
                    slot_ok && handle_ok)
                    state_next = S_WAIT_SCAN;
                else
                    state_next = S_RESP;
            end
            S_WAIT_SCAN:
            begin
                if (mode_reg == MODE_BEGIN)
                begin
                    if (!s_act || wait_last)
                        state_next = S_RESP;
                end
                else if ((s_act && !s_gr) || wait_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath: table writes, shared unit requests, counters and response
    always_comb
    begin
        wr.en       = 1'b0;
        wr.addr     = rd_addr;
        wr.data     = rd_data;
        alu_req.op  = ALU_PASS;
        alu_req.a   = rd_data.permits;
        scan_next   = scan_reg;
        wscan_next  = wscan_reg;
        used_next   = used_reg;
        status_next = status_reg;
        oidx_next   = oidx_reg;
        ogen_next   = ogen_reg;
        owait_next  = owait_reg;
        avail_next  = avail_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    scan_next   = '0;
                    wscan_next  = '0;
                    status_next = STAT_OK;
                    oidx_next   = '0;
                    ogen_next   = '0;
                    owait_next  = '0;
                    avail_next  = '0;
                end
            end

            // first dead slot takes the new handle
            S_SLOT_SCAN:
            begin
                alu_req.op = ALU_GEN_ADV;
                alu_req.a  = rd_data.gen;
                scan_next  = scan_reg + SLOT_W'(1);
                if (!rd_data.alive)
                begin
                    wr.en           = 1'b1;
                    wr.data.alive   = 1'b1;
                    wr.data.gen     = alu_y;
                    wr.data.permits = init_reg;
                    wr.data.active  = '0;
                    wr.data.granted = '0;
                    status_next     = STAT_OK;
                    oidx_next       = IDX_W'(scan_reg);
                    ogen_next       = alu_y;
                    if (USED_W'(scan_reg) >= used_reg)
                        used_next = USED_W'(scan_reg) + USED_W'(1);
                end
                else if (slot_last)
                begin
                    status_next = STAT_EXHAUSTED;
                end
            end

            // retire every slot below the high-water mark
            S_SWEEP:
            begin
                alu_req.op      = ALU_GEN_ADV;
                alu_req.a       = rd_data.gen;
                wr.en           = 1'b1;
                wr.data.alive   = 1'b0;
                wr.data.gen     = alu_y;
                wr.data.permits = '0;
                wr.data.active  = '0;
                wr.data.granted = '0;
                scan_next       = scan_reg + SLOT_W'(1);
                if (sweep_last)
                    used_next = '0;
            end

            S_LOOKUP:
            begin
                priority if (mode_reg == MODE_AVAIL)
                begin
                    if (slot_ok && handle_ok)
                        avail_next = rd_data.permits;
                end
                else if (mode_bad)
                begin
                    status_next = STAT_INVALID;
                end
                else if (is_poll_cancel && !waiter_ok)
                begin
                    status_next = STAT_INVALID;
                end
                else if (mode_reg == MODE_POLL)
                begin
                    priority if (!handle_ok)
                    begin
                        status_next = STAT_DISCONNECTED;
                    end
                    else if (!w_act)
                    begin
                        status_next = STAT_INVALID_STATE;
                    end
                    else if (cancel_reg)
                    begin
                        // a granted permit is dropped with the waiter
                        wr.en                 = 1'b1;
                        wr.data.active[wsel]  = 1'b0;
                        wr.data.granted[wsel] = 1'b0;
                        status_next           = STAT_CANCELLED;
                    end
                    else if (w_gr)
                    begin
                        wr.en                 = 1'b1;
                        wr.data.active[wsel]  = 1'b0;
                        wr.data.granted[wsel] = 1'b0;
                        oidx_next             = index_reg;
                        ogen_next             = gen_reg;
                    end
                    else if (rd_data.permits != '0)
                    begin
                        alu_req.op            = ALU_DEC;
                        wr.en                 = 1'b1;
                        wr.data.permits       = alu_y;
                        wr.data.active[wsel]  = 1'b0;
                        wr.data.granted[wsel] = 1'b0;
                        oidx_next             = index_reg;
                        ogen_next             = gen_reg;
                    end
                    else
                    begin
                        status_next = STAT_PENDING;
                    end
                end
                else if (mode_reg == MODE_CANCEL)
                begin
                    // granted permit goes back to the pool
                    if (handle_ok && w_act)
                    begin
                        alu_req.op            = w_gr ? ALU_INC_SAT : ALU_PASS;
                        wr.en                 = 1'b1;
                        wr.data.permits       = alu_y;
                        wr.data.active[wsel]  = 1'b0;
                        wr.data.granted[wsel] = 1'b0;
                    end
                end
                else if (!handle_ok)
                begin
                    status_next = STAT_STALE;
                end
                else if (mode_reg == MODE_CLOSE)
                begin
                    wr.en           = 1'b1;
                    wr.data.alive   = 1'b0;
                    wr.data.active  = '0;
                    wr.data.granted = '0;
                end
                else if (mode_reg == MODE_TRY)
                begin
                    if (rd_data.permits != '0)
                    begin
                        alu_req.op      = ALU_DEC;
                        wr.en           = 1'b1;
                        wr.data.permits = alu_y;
                        oidx_next       = index_reg;
                        ogen_next       = gen_reg;
                    end
                    else
                    begin
                        status_next = STAT_WOULD_BLOCK;
                    end
                end
                else
                begin
                    // begin and release continue in the waiter scan
                    wscan_next = '0;
                end
            end

            S_WAIT_SCAN:
            begin
                wscan_next = wscan_reg + WAIT_W'(1);
                if (mode_reg == MODE_BEGIN)
                begin
                    // lowest free waiter slot
                    if (!s_act)
                    begin
                        wr.en                      = 1'b1;
                        wr.data.active[wscan_reg]  = 1'b1;
                        wr.data.granted[wscan_reg] = 1'b0;
                        status_next                = STAT_OK;
                        oidx_next                  = index_reg;
                        ogen_next                  = gen_reg;
                        owait_next                 = WIDX_W'(wscan_reg);
                    end
                    else if (wait_last)
                    begin
                        status_next = STAT_EXHAUSTED;
                    end
                end
                else
                begin
                    // lowest waiting, ungranted waiter gets the permit
                    if (s_act && !s_gr)
                    begin
                        wr.en                      = 1'b1;
                        wr.data.granted[wscan_reg] = 1'b1;
                    end
                    else if (wait_last)
                    begin
                        alu_req.op      = ALU_INC_SAT;
                        wr.en           = 1'b1;
                        wr.data.permits = alu_y;
                    end
                end
            end

            S_RESP:
            begin
            end

            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scan_reg  <= '0;
            wscan_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            wscan_reg <= wscan_next;
            used_reg  <= used_next;
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= cmd.mode;
            index_reg  <= cmd.sem_index;
            gen_reg    <= cmd.handle_generation;
            waiter_reg <= cmd.waiter_index;
            init_reg   <= cmd.start_permits;
            cancel_reg <= cmd.cancel_request;
        end
        status_reg <= status_next;
        oidx_reg   <= oidx_next;
        ogen_reg   <= ogen_next;
        owait_reg  <= owait_next;
        avail_reg  <= avail_next;
    end

    // handshakes
    assign cmd.ready             = state_reg == S_IDLE;
    assign rsp.valid             = state_reg == S_RESP;
    assign rsp.status            = status_reg;
    assign rsp.out_index         = oidx_reg;
    assign rsp.out_generation    = ogen_reg;
    assign rsp.out_waiter        = owait_reg;
    assign rsp.permits_available = avail_reg;

endmodule

/* rtl/counting_semaphore_table_top.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_table_top
// table of counting semaphores with generation-checked handles and waiters
// ----------------------------------------------------------------------------
//  channel   dir   handshake      contents
//  cmd       in    valid/ready    mode, slot, generation, waiter, permits, cancel
//  rsp       out   valid/ready    status, slot, generation, waiter, available
//
//  one request at a time; cmd.ready is high only while the sequencer is idle
//  close, try_acquire, poll, cancel, available: lookup of the slot, then response
//  create: slot scan over k slots (1 to NUM_SEMAPHORES), then response
//  begin, release: lookup; on a valid handle, scan of k waiter bits (1 to NUM_WAITERS)
//  reset_all: sweep of slots in use, if any; the table port does one slot per cycle
//  the response holds until rsp.ready; reset clears the whole table at once
// ----------------------------------------------------------------------------
module counting_semaphore_table_top import cst_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cst_cmd_if.sink     cmd,
    cst_rsp_if.source   rsp
);

    logic [SLOT_W-1:0]  rd_addr;
    entry_t             rd_data;
    tbl_wr_t            wr;
    alu_req_t           alu_req;
    logic [GEN_W-1:0]   alu_y;

    // sequencer
    cst_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .alu_req (alu_req),
        .alu_y   (alu_y)
    );

    // slot storage
    cst_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // shared arithmetic
    cst_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

endmodule

/* rtl/cst_checker.sv */
// ----------------------------------------------------------------------------
// cst_checker
// port-level checks of the semaphore table sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cst_checker import cst_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic                    cmd_ready,
    input  logic                    rsp_valid,
    input  logic                    rsp_ready,
    input  logic [STATUS_W-1:0]     rsp_status
);

    // busy right after a request is taken
    `ASSERT_NXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    // never idle and responding at once
    `ASSERT_IMP(a_rsp_excl_idle, clk, rst_n, rsp_valid, !cmd_ready)

    // stalled response keeps its status
    `ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

    // only defined status codes
    `ASSERT_IMP(a_status_range, clk, rst_n, rsp_valid, rsp_status <= STAT_CANCELLED)

endmodule

bind counting_semaphore_table_top cst_checker u_cst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status)
);
